### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = 4;
  localparam int unsigned HALF_W        = 16;
  localparam int unsigned POLL_W        = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_WACK  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIM = 1'd1;

  localparam logic [HALF_W-1:0] HALF_BIT_RESET = 16'd100;
  localparam logic [POLL_W-1:0] POLL_LIM_RESET = 8'd250;

  typedef struct packed {
    logic [HALF_W-1:0] half_bit_ticks;
    logic [POLL_W-1:0] ack_poll_limit;
  } i2cm_cfg_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } i2cm_res_t;

endpackage

### rtl/i2cm_in_if.sv
// ----------------------------------------------------------------------------
// i2cm_in_if
// Request channel: one tick with optional command and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, req_type, tx_byte, send_ack, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, req_type, tx_byte, send_ack, sda_in,
                  output ready);
endinterface

### rtl/i2cm_out_if.sv
// ----------------------------------------------------------------------------
// i2cm_out_if
// Result channel: bus pin levels and status after each tick.
// ----------------------------------------------------------------------------
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                  rx_byte, ack_failed, input ready);
  modport sink   (input valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                  rx_byte, ack_failed, output ready);
endinterface

### rtl/i2cm_cfg.sv
// ----------------------------------------------------------------------------
// i2cm_cfg
// Configuration registers: half-bit delay and ack poll limit.
// ----------------------------------------------------------------------------
module i2cm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output i2cm_pkg::i2cm_cfg_t                cfg
);
  import i2cm_pkg::*;

  logic [HALF_W-1:0] half_r;
  logic [POLL_W-1:0] poll_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r     <= HALF_BIT_RESET;
      poll_lim_r <= POLL_LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HALF_BIT: half_r     <= cfg_wdata[HALF_W-1:0];
        CFG_POLL_LIM: poll_lim_r <= cfg_wdata[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.half_bit_ticks = half_r;
  assign cfg.ack_poll_limit = poll_lim_r;

endmodule

### rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances at most one step per accepted tick and produces
// the pin levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 cmd_valid,
  input  logic [2:0]           req_type,
  input  logic [7:0]           tx_byte,
  input  logic                 send_ack,
  input  logic                 sda_in,
  input  i2cm_pkg::i2cm_cfg_t  cfg,
  output i2cm_pkg::i2cm_res_t  res_nxt
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_P0, PH_P1, PH_WA, PH_WB,
    PH_A0, PH_A1, PH_A2, PH_R0, PH_R1, PH_K0, PH_K1, PH_K2, PH_FIN
  } phase_t;

  localparam logic [BIT_CNT_W-1:0] BYTE_BITS = BIT_CNT_W'(BITS_PER_BYTE);

  phase_t               phase_r, phase_nxt, ph;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [HALF_W-1:0]    delay_r, delay_nxt;
  logic [POLL_W-1:0]    poll_r, poll_nxt;
  logic                 ack_sel_r, ack_sel_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 sda_en_r, sda_en_nxt;
  logic                 fail_r, fail_nxt;
  logic [7:0]           rx_r, rx_nxt;
  logic                 run;
  logic                 done;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    delay_nxt   = delay_r;
    poll_nxt    = poll_r;
    ack_sel_nxt = ack_sel_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    sda_en_nxt  = sda_en_r;
    fail_nxt    = fail_r;
    rx_nxt      = rx_r;
    run         = 1'b0;
    done        = 1'b0;
    ph          = phase_r;

    if (phase_r == PH_IDLE) begin
      if (cmd_valid && (req_type <= REQ_READ)) begin
        bit_cnt_nxt = '0;
        poll_nxt    = '0;
        delay_nxt   = '0;
        run         = 1'b1;
        unique case (req_type)
          REQ_START: ph = PH_S0;
          REQ_STOP:  ph = PH_P0;
          REQ_WRITE: begin
            shift_nxt = tx_byte;
            ph        = PH_WA;
          end
          REQ_WACK:  ph = PH_A0;
          default: begin
            shift_nxt   = '0;
            ack_sel_nxt = send_ack;
            ph          = PH_R0;
          end
        endcase
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - 1'b1;
    end else begin
      run = 1'b1;
    end

    if (run) begin
      unique case (ph)
        PH_S0: begin
          sda_en_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
          delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_S1;
        end
        PH_S1: begin
          sda_nxt   = 1'b0;
          delay_nxt = cfg.half_bit_ticks; phase_nxt = PH_S2;
        end
        PH_S2: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_P0: begin
          sda_en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
          delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_P1;
        end
        PH_P1: begin
          scl_nxt   = 1'b1; sda_nxt = 1'b1;
          delay_nxt = cfg.half_bit_ticks; phase_nxt = PH_FIN;
        end
        PH_WA: begin
          sda_en_nxt = 1'b1;
          sda_nxt    = shift_nxt[7];
          shift_nxt  = {shift_nxt[6:0], 1'b0};
          scl_nxt    = 1'b1;
          delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_WB;
        end
        PH_WB: begin
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bit_cnt_nxt + 1'b1;
          delay_nxt   = cfg.half_bit_ticks;
          phase_nxt   = (bit_cnt_nxt >= BYTE_BITS) ? PH_FIN : PH_WA;
        end
        PH_A0: begin
          sda_en_nxt = 1'b0; sda_nxt = 1'b1;
          delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_A1;
        end
        PH_A1: begin
          scl_nxt   = 1'b1;
          delay_nxt = cfg.half_bit_ticks; phase_nxt = PH_A2;
        end
        PH_A2: begin
          if (!sda_in) begin
            scl_nxt = 1'b0; fail_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
          end else if (poll_r >= cfg.ack_poll_limit) begin
            // timeout: straight into the first stop step
            fail_nxt   = 1'b1;
            sda_en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
            delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_P1;
          end else begin
            poll_nxt = poll_r + 1'b1;
          end
        end
        PH_R0: begin
          sda_en_nxt = 1'b0; sda_nxt = 1'b1; scl_nxt = 1'b0;
          delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_R1;
        end
        PH_R1: begin
          scl_nxt     = 1'b1;
          shift_nxt   = {shift_nxt[6:0], sda_in};
          bit_cnt_nxt = bit_cnt_nxt + 1'b1;
          delay_nxt   = cfg.half_bit_ticks;
          phase_nxt   = (bit_cnt_nxt >= BYTE_BITS) ? PH_K0 : PH_R0;
        end
        PH_K0: begin
          scl_nxt    = 1'b0; sda_en_nxt = 1'b1;
          sda_nxt    = ~ack_sel_nxt;
          delay_nxt  = cfg.half_bit_ticks; phase_nxt = PH_K1;
        end
        PH_K1: begin
          scl_nxt   = 1'b1;
          delay_nxt = cfg.half_bit_ticks; phase_nxt = PH_K2;
        end
        PH_K2: begin
          scl_nxt = 1'b0; rx_nxt = shift_nxt; phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_FIN: begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      delay_r   <= '0;
      poll_r    <= '0;
      ack_sel_r <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      sda_en_r  <= 1'b1;
      fail_r    <= 1'b0;
      rx_r      <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      delay_r   <= delay_nxt;
      poll_r    <= poll_nxt;
      ack_sel_r <= ack_sel_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      sda_en_r  <= sda_en_nxt;
      fail_r    <= fail_nxt;
      rx_r      <= rx_nxt;
    end
  end

  assign res_nxt.scl_out    = scl_nxt;
  assign res_nxt.sda_out    = sda_nxt;
  assign res_nxt.sda_drive  = sda_en_nxt;
  assign res_nxt.busy_res   = (phase_nxt != PH_IDLE);
  assign res_nxt.done_res   = done;
  assign res_nxt.rx_byte    = rx_nxt;
  assign res_nxt.ack_failed = fail_nxt;

endmodule

### rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that runs start, stop, write byte, wait ack and read byte.
// ----------------------------------------------------------------------------
// Each request is one bus tick; the engine takes one request per clock and
// returns one result per request, held in an output register in the next cycle.
// A new request is taken while the output register is empty or being read, so
// the sustained rate is one request per clock, set by the single sequencer
// step between the state registers and the output register. Commands offered
// while busy or with an unknown type are ignored.
module i2c_master_byte_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cm_in_if.sink                           in_ch,
  i2cm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cm_pkg::*;

  i2cm_cfg_t cfg;
  i2cm_res_t res_nxt;
  i2cm_res_t res_r;
  logic      out_valid_r;
  logic      accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept),
    .cmd_valid (in_ch.cmd_valid),
    .req_type  (in_ch.req_type),
    .tx_byte   (in_ch.tx_byte),
    .send_ack  (in_ch.send_ack),
    .sda_in    (in_ch.sda_in),
    .cfg       (cfg),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_out    = res_r.scl_out;
  assign out_ch.sda_out    = res_r.sda_out;
  assign out_ch.sda_drive  = res_r.sda_drive;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.rx_byte    = res_r.rx_byte;
  assign out_ch.ack_failed = res_r.ack_failed;

endmodule

### rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master byte engine.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_out,
  input logic       sda_out,
  input logic       sda_drive,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rx_byte,
  input logic       ack_failed
);

  // room for a request whenever the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output register");

  // each accepted request yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

  // a released SDA line is reported high, and completion ends busy
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !sda_drive) |-> sda_out)
    else $error("SDA released but level low");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while still busy");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(scl_out) && $stable(rx_byte) && $stable(ack_failed)))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .scl_out    (out_ch.scl_out),
  .sda_out    (out_ch.sda_out),
  .sda_drive  (out_ch.sda_drive),
  .busy_res   (out_ch.busy_res),
  .done_res   (out_ch.done_res),
  .rx_byte    (out_ch.rx_byte),
  .ack_failed (out_ch.ack_failed)
);

### tb/i2c_master_byte_engine_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the I2C master byte engine. Every request is one bus
// tick; a cycle-accurate model of the bus sequencer predicts the pin levels
// and status of each tick. Commands are issued when the model shows the engine
// idle, SDA is steered through ack polls and read bits, and random gaps and
// back-pressure are applied on both channels across several delay and poll
// limit settings.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam int WDOG_LIMIT = 4000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_S0, ST_S1, ST_S2, ST_P0, ST_P1, ST_WA, ST_WB,
    ST_A0, ST_A1, ST_A2, ST_R0, ST_R1, ST_K0, ST_K1, ST_K2, ST_FIN
  } seq_phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
  } bus_tick_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_byte_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // bus sequencer model
  seq_phase_e  m_phase  = ST_IDLE;
  logic [3:0]  m_bits   = '0;
  logic [7:0]  m_shift  = '0;
  logic [15:0] m_delay  = '0;
  logic [7:0]  m_polls  = '0;
  logic        m_ack_sel = 1'b0;
  logic        m_scl    = 1'b1;
  logic        m_sda    = 1'b1;
  logic        m_sda_en = 1'b1;
  logic        m_fail   = 1'b0;
  logic [7:0]  m_rx     = '0;
  logic [15:0] cfg_half = HALF_BIT_RESET;
  logic [7:0]  cfg_poll = POLL_LIM_RESET;

  bus_tick_t pend_q[$];
  i2cm_res_t exp_q[$];

  bit  gaps_on = 1'b1;
  bit  in_taken;
  bit  out_taken;
  int  ticks_sent;
  int  ticks_taken;
  int  results_seen;
  int  err_cnt;
  int  idle_cycles;
  int  in_wait;
  int  out_wait;
  bus_tick_t drv_tick;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd_valid = 1'b0;
    in_ch.req_type  = '0;
    in_ch.tx_byte   = '0;
    in_ch.send_ack  = 1'b0;
    in_ch.sda_in    = 1'b1;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one sequencer step; returns 1 when the command completes
  function automatic logic bus_step(input logic sda);
    logic fin;
    fin = 1'b0;
    case (m_phase)
      ST_S0: begin
        m_sda_en = 1'b1; m_sda = 1'b1; m_scl = 1'b1;
        m_delay = cfg_half; m_phase = ST_S1;
      end
      ST_S1: begin
        m_sda = 1'b0; m_delay = cfg_half; m_phase = ST_S2;
      end
      ST_S2: begin
        m_scl = 1'b0; m_phase = ST_IDLE; fin = 1'b1;
      end
      ST_P0: begin
        m_sda_en = 1'b1; m_scl = 1'b0; m_sda = 1'b0;
        m_delay = cfg_half; m_phase = ST_P1;
      end
      ST_P1: begin
        m_scl = 1'b1; m_sda = 1'b1; m_delay = cfg_half; m_phase = ST_FIN;
      end
      ST_WA: begin
        m_sda_en = 1'b1; m_sda = m_shift[7]; m_shift = {m_shift[6:0], 1'b0};
        m_scl = 1'b1; m_delay = cfg_half; m_phase = ST_WB;
      end
      ST_WB: begin
        m_scl = 1'b0; m_bits = m_bits + 4'd1; m_delay = cfg_half;
        if (m_bits >= 4'(BITS_PER_BYTE)) m_phase = ST_FIN;
        else m_phase = ST_WA;
      end
      ST_A0: begin
        m_sda_en = 1'b0; m_sda = 1'b1; m_delay = cfg_half; m_phase = ST_A1;
      end
      ST_A1: begin
        m_scl = 1'b1; m_delay = cfg_half; m_phase = ST_A2;
      end
      ST_A2: begin
        if (!sda) begin
          m_scl = 1'b0; m_fail = 1'b0; m_phase = ST_IDLE; fin = 1'b1;
        end else if (m_polls >= cfg_poll) begin
          // timeout: flag it and run the first stop step on this tick
          m_fail = 1'b1;
          m_sda_en = 1'b1; m_scl = 1'b0; m_sda = 1'b0;
          m_delay = cfg_half; m_phase = ST_P1;
        end else begin
          m_polls = m_polls + 8'd1;
        end
      end
      ST_R0: begin
        m_sda_en = 1'b0; m_sda = 1'b1; m_scl = 1'b0;
        m_delay = cfg_half; m_phase = ST_R1;
      end
      ST_R1: begin
        m_scl = 1'b1; m_shift = {m_shift[6:0], sda}; m_bits = m_bits + 4'd1;
        m_delay = cfg_half;
        if (m_bits >= 4'(BITS_PER_BYTE)) m_phase = ST_K0;
        else m_phase = ST_R0;
      end
      ST_K0: begin
        m_scl = 1'b0; m_sda_en = 1'b1; m_sda = ~m_ack_sel;
        m_delay = cfg_half; m_phase = ST_K1;
      end
      ST_K1: begin
        m_scl = 1'b1; m_delay = cfg_half; m_phase = ST_K2;
      end
      ST_K2: begin
        m_scl = 1'b0; m_rx = m_shift; m_phase = ST_IDLE; fin = 1'b1;
      end
      ST_FIN: begin
        m_phase = ST_IDLE; fin = 1'b1;
      end
      default: m_phase = ST_IDLE;
    endcase
    return fin;
  endfunction

  function automatic i2cm_res_t predict_tick(input bus_tick_t t);
    i2cm_res_t r;
    logic fin;
    fin = 1'b0;
    if (m_phase == ST_IDLE) begin
      if (t.cmd_valid && t.req <= REQ_READ) begin
        m_bits = '0; m_polls = '0; m_delay = '0;
        case (t.req)
          REQ_START: m_phase = ST_S0;
          REQ_STOP:  m_phase = ST_P0;
          REQ_WRITE: begin m_shift = t.tx; m_phase = ST_WA; end
          REQ_WACK:  m_phase = ST_A0;
          default:   begin m_shift = '0; m_ack_sel = t.ack; m_phase = ST_R0; end
        endcase
        fin = bus_step(t.sda);
      end
    end else if (m_delay != '0) begin
      m_delay = m_delay - 16'd1;
    end else begin
      fin = bus_step(t.sda);
    end
    r.scl_out    = m_scl;
    r.sda_out    = m_sda;
    r.sda_drive  = m_sda_en;
    r.busy_res   = (m_phase != ST_IDLE);
    r.done_res   = fin;
    r.rx_byte    = m_rx;
    r.ack_failed = m_fail;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] got,
                           input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s got %0h want %0h",
                             results_seen, name, got, want));
  endtask

  // check, config and prediction share one edge, in that order
  always @(posedge clk) begin
    i2cm_res_t want;
    if (!rst_n) begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
    end else begin
      in_taken  = in_ch.valid && in_ch.ready;
      out_taken = out_ch.valid && out_ch.ready;
      if (out_taken) begin
        if (exp_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = exp_q.pop_front();
          cmp_field("scl_out",    out_ch.scl_out,    want.scl_out);
          cmp_field("sda_out",    out_ch.sda_out,    want.sda_out);
          cmp_field("sda_drive",  out_ch.sda_drive,  want.sda_drive);
          cmp_field("busy_res",   out_ch.busy_res,   want.busy_res);
          cmp_field("done_res",   out_ch.done_res,   want.done_res);
          cmp_field("rx_byte",    out_ch.rx_byte,    want.rx_byte);
          cmp_field("ack_failed", out_ch.ack_failed, want.ack_failed);
        end
        results_seen++;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HALF_BIT: cfg_half = cfg_wdata;
          CFG_POLL_LIM: cfg_poll = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        exp_q.push_back(predict_tick({in_ch.cmd_valid, in_ch.req_type,
                                      in_ch.tx_byte, in_ch.send_ack, in_ch.sda_in}));
        ticks_taken++;
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait = 0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_wait > 0) begin
        in_wait--;
        in_ch.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        drv_tick = pend_q.pop_front();
        in_ch.cmd_valid <= drv_tick.cmd_valid;
        in_ch.req_type  <= drv_tick.req;
        in_ch.tx_byte   <= drv_tick.tx;
        in_ch.send_ack  <= drv_tick.ack;
        in_ch.sda_in    <= drv_tick.sda;
        in_ch.valid     <= 1'b1;
        in_wait = gaps_on ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_wait = gaps_on ? pick_gap() : 0;
    end
  end

  task automatic send_tick(input bus_tick_t t);
    pend_q.push_back(t);
    ticks_sent++;
    while (ticks_taken != ticks_sent) begin
      @(posedge clk);
      #1;
    end
  endtask

  // issue one command and tick until the model is idle again;
  // hi_polls high SDA samples precede the ack, sda_fix 2 means random SDA
  task automatic run_cmd(input logic [2:0] req, input logic [7:0] tx,
                         input logic ack, input int hi_polls, input int sda_fix);
    bus_tick_t t;
    int sda_hi;
    sda_hi = hi_polls;
    t.cmd_valid = 1'b1;
    t.req = req;
    t.tx  = tx;
    t.ack = ack;
    t.sda = 1'($urandom_range(0, 1));
    send_tick(t);
    while (m_phase != ST_IDLE) begin
      t.cmd_valid = ($urandom_range(0, 9) == 0);
      t.req = 3'($urandom_range(0, 7));
      t.tx  = 8'($urandom);
      t.ack = 1'($urandom_range(0, 1));
      if (m_phase == ST_A2 && m_delay == '0) begin
        t.sda = (sda_hi > 0);
        if (sda_hi > 0) sda_hi--;
      end else if (sda_fix == 2) begin
        t.sda = 1'($urandom_range(0, 1));
      end else begin
        t.sda = sda_fix[0];
      end
      send_tick(t);
    end
  endtask

  task automatic idle_tick();
    bus_tick_t t;
    t.cmd_valid = 1'($urandom_range(0, 1));
    t.req = t.cmd_valid ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 7));
    t.tx  = 8'($urandom);
    t.ack = 1'($urandom_range(0, 1));
    t.sda = 1'($urandom_range(0, 1));
    send_tick(t);
  endtask

  task automatic random_cmd();
    logic [2:0] req;
    int hi;
    if ($urandom_range(0, 9) == 0) req = 3'($urandom_range(5, 7));
    else req = 3'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: hi = $urandom_range(0, 3);
      6:       hi = int'(cfg_poll);
      7:       hi = cfg_poll + 1;
      8:       hi = $urandom_range(0, cfg_poll);
      default: hi = cfg_poll + 1 + $urandom_range(0, 3);
    endcase
    run_cmd(req, 8'($urandom), 1'($urandom_range(0, 1)), hi, 2);
  endtask

  // random commands until about n more ticks have been sent
  task automatic run_random(input int n);
    int stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 63) == 0) gaps_on = ~gaps_on;
      if ($urandom_range(0, 3) == 0) idle_tick();
      random_cmd();
    end
    gaps_on = 1'b1;
  endtask

  task automatic write_cfg(input logic [15:0] half, input logic [7:0] poll);
    logic [7:0] junk;
    junk = 8'($urandom);
    while (exp_q.size() != 0 || pend_q.size() != 0 || in_ch.valid) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HALF_BIT;
    cfg_wdata <= half;
    @(negedge clk);
    cfg_idx   <= CFG_POLL_LIM;
    cfg_wdata <= {junk, poll};   // upper bits must be dropped
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    #1;

    // reset settings: one start, unknown request types and an idle tick
    run_cmd(REQ_START, 8'h00, 1'b0, 0, 2);
    run_cmd(3'd5, 8'h00, 1'b0, 0, 2);
    run_cmd(3'd6, 8'h00, 1'b0, 0, 2);
    run_cmd(3'd7, 8'h00, 1'b0, 0, 2);
    idle_tick();

    // no delay between steps, first high poll fails
    write_cfg(16'd0, 8'd0);
    run_cmd(REQ_WACK,  8'h00, 1'b0, 1, 2);
    run_cmd(REQ_WACK,  8'h00, 1'b0, 0, 2);
    run_cmd(REQ_WRITE, 8'h00, 1'b0, 0, 2);
    run_cmd(REQ_WRITE, 8'hFF, 1'b0, 0, 2);
    run_cmd(REQ_WRITE, 8'h3C, 1'b0, 0, 2);
    run_cmd(REQ_READ,  8'h00, 1'b1, 0, 1);
    run_cmd(REQ_READ,  8'h00, 1'b0, 0, 0);
    run_cmd(REQ_STOP,  8'h00, 1'b0, 0, 2);
    run_random(150);

    write_cfg(16'd1, 8'd1);
    run_random(180);

    write_cfg(16'd0, 8'd40);
    run_random(100);

    write_cfg(16'd2, 8'd3);
    run_random(140);

    repeat (3) begin
      write_cfg(16'($urandom_range(0, 4)), 8'($urandom_range(1, 20)));
      run_random(70);
    end

    while (exp_q.size() != 0 || pend_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
